// ===== design/newton_square_root_macros.svh =====
// Assertion macros shared by the newton_square_root RTL.
`ifndef NEWTON_SQUARE_ROOT_MACROS_SVH
`define NEWTON_SQUARE_ROOT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, quiet during reset.
`define NSR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on clk, quiet during reset.
`define NSR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NSR_ASSERT_IMP(label, ante, cons)
`define NSR_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== design/nsr_pkg.sv =====
// Shared constants and types for the Newton square root block.
`default_nettype none
package nsr_pkg;

  // Default fixed-point format and step cap
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned MAX_ITER_DEF  = 32;

  // Guess and divisor width, and default dividend width (31 magnitude bits shifted)
  localparam int unsigned GUESS_W   = 32;
  localparam int unsigned DVD_W_DEF = 31 + FRAC_BITS_DEF;

  // Configuration register indexes and reset values
  localparam logic REG_EPSILON = 1'b0;
  localparam logic [31:0] EPSILON_RESET = 32'd1;

  // Result status codes
  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_NEG = 2'd1;
  localparam logic [1:0] STATUS_CAP = 2'd2;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } nsr_div_stat_t;

endpackage
`default_nettype wire

// ===== design/nsr_cfg.sv =====
// APB-style register file holding the convergence tolerance.
`default_nettype none
module nsr_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] epsilon
);
  import nsr_pkg::*;

  logic [31:0] eps_r;
  logic        wr_beat;
  logic        reg_idx;

  // Register index is the word address
  assign reg_idx = paddr[2];
  assign wr_beat = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Write the tolerance on the access beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPSILON_RESET;
    end else if (wr_beat && reg_idx == REG_EPSILON) begin
      eps_r <= pwdata;
    end
  end

  // Read back; addresses past the list read as zero
  always_comb begin
    unique case (reg_idx)
      REG_EPSILON: prdata = eps_r;
      default:     prdata = '0;
    endcase
  end

  assign epsilon = eps_r;
endmodule
`default_nettype wire

// ===== design/nsr_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module nsr_div #(
  parameter int unsigned DVD_W = nsr_pkg::DVD_W_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [DVD_W-1:0]             dividend,
  input  logic [nsr_pkg::GUESS_W-1:0]  divisor,
  output logic [DVD_W-1:0]             quotient,
  output nsr_pkg::nsr_div_stat_t       stat
);
  import nsr_pkg::*;

  localparam int unsigned CW = $clog2(DVD_W);

  logic [GUESS_W-1:0] rem_r, rem_nxt;
  logic [GUESS_W-1:0] dsr_r;
  logic [DVD_W-1:0]   quo_r, quo_nxt;
  logic [CW-1:0]      cnt_r;
  logic               busy_r, done_r;
  logic [GUESS_W:0]   trial;
  logic [GUESS_W:0]   diffv;
  logic               take;

  // Shift the next dividend bit into the partial remainder and trial-subtract
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diffv = trial - {1'b0, dsr_r};
  assign take  = ~diffv[GUESS_W];

  always_comb begin
    rem_nxt = take ? diffv[GUESS_W-1:0] : trial[GUESS_W-1:0];
    quo_nxt = {quo_r[DVD_W-2:0], take};
  end

  // Control: count DVD_W steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CW'(DVD_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(DVD_W - 1)) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then advance one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule
`default_nettype wire

// ===== design/newton_square_root.sv =====
// Top level: Newton-Raphson square root sequencer around a bit-serial divider.
//
//  channel  ports                           beat taken when
//  -------  ------------------------------  -----------------------------------
//  input    start, busy, in_value           start high and busy low
//  result   out_valid, out_root, out_status out_valid high (one cycle only)
//  config   psel..prdata, pready            psel, penable, pwrite, pready high
//
// Negative, zero and exactly-one inputs give their result the cycle after the beat.
// Otherwise the block runs up to MAX_ITER Newton steps, each paced by the serial
// divider at one quotient bit a cycle; the result shows once the last step is checked.
// Synchronous active-low reset; epsilon returns to 1. The receiver cannot stall,
// so a result is shown for exactly one cycle and a new item may start meanwhile.
`default_nettype none
`include "newton_square_root_macros.svh"
module newton_square_root #(
  parameter int unsigned FRAC_BITS = nsr_pkg::FRAC_BITS_DEF,
  parameter int unsigned MAX_ITER  = nsr_pkg::MAX_ITER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic [31:0]        out_root,
  output logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import nsr_pkg::*;

  localparam int unsigned DW = 31 + FRAC_BITS;
  localparam int unsigned IW = $clog2(MAX_ITER + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_DIFF  = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [30:0]        raw_r;
  logic [31:0]        prev_r, next_r, diff_r;
  logic [IW-1:0]      iter_r;
  logic               out_valid_r;
  logic [31:0]        out_root_r;
  logic [1:0]         out_status_r;
  logic [31:0]        epsilon;
  logic [31:0]        guess;
  logic [DW-1:0]      quotient;
  logic [DW:0]        sum;
  logic [32:0]        d_fwd, d_rev;
  logic               div_start;
  logic               accept;
  logic               is_one;
  nsr_div_stat_t      div_stat;

  nsr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .epsilon (epsilon)
  );

  // A zero guess divides as one
  assign guess     = (prev_r == '0) ? 32'd1 : prev_r;
  assign div_start = (state_r == S_LOAD);

  nsr_div #(.DVD_W(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({raw_r, FRAC_BITS'(0)}),
    .divisor  (guess),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start & ~busy;
  assign is_one = (in_value == (32'sd1 <<< FRAC_BITS));

  // Average guess and quotient; distances both ways for the tolerance check
  assign sum   = {1'b0, quotient} + (DW + 1)'(guess);
  assign d_fwd = {1'b0, prev_r} - {1'b0, next_r};
  assign d_rev = {1'b0, next_r} - {1'b0, prev_r};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !in_value[31] && in_value != '0 && !is_one) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: state_nxt = S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD:  state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_CHECK;
      S_CHECK: begin
        if (diff_r <= epsilon || iter_r >= IW'(MAX_ITER)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (accept && (in_value[31] || in_value == '0 || is_one)) ||
                     (state_r == S_CHECK && state_nxt == S_IDLE);
      if (accept) begin
        iter_r <= IW'(1);
      end else if (state_r == S_CHECK && state_nxt == S_LOAD) begin
        iter_r <= iter_r + 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      raw_r  <= in_value[30:0];
      prev_r <= 32'(unsigned'(in_value));
      if (in_value[31]) begin
        out_root_r   <= '0;
        out_status_r <= STATUS_NEG;
      end else begin
        out_root_r   <= 32'(unsigned'(in_value));
        out_status_r <= STATUS_OK;
      end
    end
    if (state_r == S_UPD) begin
      next_r <= sum[32:1];
    end
    if (state_r == S_DIFF) begin
      diff_r <= d_fwd[32] ? d_rev[31:0] : d_fwd[31:0];
    end
    if (state_r == S_CHECK) begin
      out_root_r   <= next_r;
      out_status_r <= (diff_r <= epsilon) ? STATUS_OK : STATUS_CAP;
      prev_r       <= next_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_root   = out_root_r;
  assign out_status = out_status_r;

  // Checks
  `NSR_ASSERT_IMP(a_status_code, out_valid, out_status != 2'd3)
  `NSR_ASSERT_IMP(a_neg_zero, out_valid && out_status == STATUS_NEG, out_root == '0)
  `NSR_ASSERT_NXT(a_conv_out, state_r == S_CHECK && diff_r <= epsilon,
                  out_valid && out_status == STATUS_OK)
  `NSR_ASSERT_IMP(a_div_in_step, div_stat.busy, state_r == S_DIV)
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for newton_square_root: directed table, then random beats per epsilon.
module tb_top;
  import nsr_pkg::*;

  localparam int unsigned FRAC              = FRAC_BITS_DEF;
  localparam int unsigned STEP_CAP          = MAX_ITER_DEF;
  localparam int unsigned ITEMS_PER_SETTING = 125;
  localparam int unsigned SETTINGS_RUN      = 6;
  localparam int unsigned IDLE_LIMIT        = 20000;
  localparam int unsigned TAIL_CYCLES       = 1700;
  localparam int unsigned REPORT_LIMIT      = 10;

  typedef struct packed {
    logic [31:0] root;
    logic [1:0]  status;
  } sqrt_res_t;

  typedef struct packed {
    logic [31:0] value;
    logic        known;
    logic [31:0] root;
    logic [1:0]  status;
  } drill_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic [31:0]        out_root;
  logic [1:0]         out_status;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow of the epsilon register and the roots still owed by the block
  logic [31:0] tolerance;
  sqrt_res_t   pending_roots[$];
  sqrt_res_t   oldest_root;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  // Directed rows: typed expectations only where they are obvious
  drill_row_t drill_rows [21] = '{
    '{32'h8000_0000, 1'b1, 32'h0000_0000, STATUS_NEG},
    '{32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STATUS_NEG},
    '{32'hC000_0000, 1'b1, 32'h0000_0000, STATUS_NEG},
    '{32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_OK},
    '{32'h0001_0000, 1'b1, 32'h0001_0000, STATUS_OK},
    '{32'h7FFF_FFFF, 1'b0, 32'h0, STATUS_OK},
    '{32'h0000_0001, 1'b0, 32'h0, STATUS_OK},
    '{32'h0000_0002, 1'b0, 32'h0, STATUS_OK},
    '{32'h0000_FFFF, 1'b0, 32'h0, STATUS_OK},
    '{32'h0001_0001, 1'b0, 32'h0, STATUS_OK},
    '{32'h0002_0000, 1'b0, 32'h0, STATUS_OK},
    '{32'h0004_0000, 1'b0, 32'h0, STATUS_OK},
    '{32'h0064_0000, 1'b0, 32'h0, STATUS_OK},
    '{32'h0000_8000, 1'b0, 32'h0, STATUS_OK},
    '{32'h4000_0000, 1'b0, 32'h0, STATUS_OK},
    '{32'h5555_5555, 1'b0, 32'h0, STATUS_OK},
    '{32'h2AAA_AAAA, 1'b0, 32'h0, STATUS_OK},
    '{32'h1234_5678, 1'b0, 32'h0, STATUS_OK},
    '{32'h7FFF_0000, 1'b0, 32'h0, STATUS_OK},
    '{32'h0001_0000, 1'b1, 32'h0001_0000, STATUS_OK},
    '{32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_OK}
  };

  // Epsilon settings walked by the random part; the random slot is filled at run time
  logic [31:0] eps_settings [SETTINGS_RUN] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h0000_0100, 32'h0000_0000, 32'h0001_0000
  };

  newton_square_root dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_root   (out_root),
    .out_status (out_status),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5ns clk = ~clk;

  // One Newton step: average of the guess and the fixed-point quotient, truncated
  function automatic logic [63:0] newton_halve(logic [63:0] radicand, logic [63:0] guess);
    logic [63:0] divisor;
    divisor = (guess == 64'd0) ? 64'd1 : guess;
    return (divisor + ((radicand << FRAC) / divisor)) >> 1;
  endfunction

  // Expected root and status for one value under the given tolerance
  function automatic sqrt_res_t predict_sqrt(logic [31:0] value, logic [31:0] tol);
    sqrt_res_t   res;
    logic [63:0] radicand;
    logic [63:0] prev_guess;
    logic [63:0] cand_guess;
    logic [63:0] guess_gap;
    int unsigned steps;
    bit          settled;
    radicand = {32'd0, value};
    if (value[31]) begin
      res.root   = 32'd0;
      res.status = STATUS_NEG;
      return res;
    end
    if (radicand == 64'd0 || radicand == (64'd1 << FRAC)) begin
      res.root   = value;
      res.status = STATUS_OK;
      return res;
    end
    prev_guess = radicand;
    cand_guess = newton_halve(radicand, prev_guess);
    steps      = 1;
    settled    = 1'b0;
    res.status = STATUS_OK;
    while (!settled) begin
      guess_gap = (prev_guess > cand_guess) ? prev_guess - cand_guess
                                            : cand_guess - prev_guess;
      if (guess_gap <= {32'd0, tol}) begin
        res.status = STATUS_OK;
        settled    = 1'b1;
      end else if (steps >= STEP_CAP) begin
        res.status = STATUS_CAP;
        settled    = 1'b1;
      end else begin
        prev_guess = cand_guess;
        cand_guess = newton_halve(radicand, prev_guess);
        steps++;
      end
    end
    res.root = cand_guess[31:0];
    return res;
  endfunction

  // Random value, weighted towards the corners of the Newton loop
  function automatic logic [31:0] draw_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return 32'($urandom) | 32'h8000_0000;
    if (pick < 14) return 32'h0000_0000;
    if (pick < 18) return 32'h0001_0000;
    if (pick < 40) return 32'($urandom_range(1, 32'h0004_0000));
    if (pick < 55) return 32'h7FFF_FFFF - 32'($urandom_range(0, 32'h0001_0000));
    return 32'($urandom) & 32'h7FFF_FFFF;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t: mismatch: %s", $realtime, msg);
  endtask

  // Offer one value and hold it until the beat is taken
  task automatic offer_value(input logic [31:0] value, input sqrt_res_t want);
    start    <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (busy);
    pending_roots.push_back(want);
  endtask

  // Drop start for a gap between bursts; a zero gap keeps start high
  task automatic pause_sender(input int unsigned gap);
    if (gap > 0) begin
      start    <= 1'b0;
      in_value <= 32'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every owed root has come and the block is idle
  task automatic drain_results();
    start <= 1'b0;
    while (pending_roots.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_EPSILON, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel      <= 1'b0;
    penable   <= 1'b0;
    tolerance  = data;
  endtask

  task automatic cfg_check(input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_EPSILON, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      flag_mismatch($sformatf("epsilon read expected %h got %h", want, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Compare each result beat with the oldest owed root
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_roots.size() == 0) begin
        flag_mismatch($sformatf("unexpected result root %h status %0d", out_root, out_status));
      end else begin
        oldest_root = pending_roots.pop_front();
        if (out_root !== oldest_root.root || out_status !== oldest_root.status)
          flag_mismatch($sformatf("root expected %h got %h, status expected %0d got %0d",
                                  oldest_root.root, out_root, oldest_root.status, out_status));
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    logic [31:0] value;
    drill_row_t  row;
    sqrt_res_t   want;

    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_value <= 32'sd0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= 3'd0;
    pwdata   <= 32'd0;
    tolerance = EPSILON_RESET;
    eps_settings[4] = 32'($urandom_range(3, 4095));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_check(EPSILON_RESET);

    // Directed table under the reset tolerance
    foreach (drill_rows[i]) begin
      row  = drill_rows[i];
      want = row.known ? sqrt_res_t'{row.root, row.status} : predict_sqrt(row.value, tolerance);
      offer_value(row.value, want);
      pause_sender($urandom_range(0, 3));
    end
    drain_results();

    // Random bursts, one block per epsilon setting
    for (int unsigned s = 0; s < SETTINGS_RUN; s++) begin
      cfg_write(eps_settings[s]);
      @(posedge clk);
      cfg_check(eps_settings[s]);
      sent = 0;
      while (sent < ITEMS_PER_SETTING) begin
        burst = $urandom_range(1, 12);
        for (int unsigned b = 0; b < burst && sent < ITEMS_PER_SETTING; b++) begin
          value = draw_value();
          offer_value(value, predict_sqrt(value, tolerance));
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        pause_sender(gap);
        if ($urandom_range(0, 29) == 0) drain_results();
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_roots.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
